// ----- src/ubx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_pkg
// shared types and constants for the ubx frame receiver
// ----------------------------------------------------------------------------
package ubx_pkg;

    localparam int STORE_DEPTH = 512;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam logic [7:0] NMEA_START     = 8'h24;
    localparam logic [7:0] NMEA_LF        = 8'h0A;
    localparam logic [7:0] NMEA_BAD_ABOVE = 8'h80;
    localparam logic [7:0] UBX_SYNC1      = 8'hB5;
    localparam logic [7:0] UBX_SYNC2      = 8'h62;
    localparam logic [7:0] CLS_NAV        = 8'h01;
    localparam logic [7:0] CLS_ACK        = 8'h05;
    localparam logic [7:0] CLS_CFG        = 8'h06;
    localparam logic [7:0] ID_ACK_ACK     = 8'h01;
    localparam logic [7:0] ID_CFG_RXM     = 8'h11;
    localparam logic [7:0] ID_NAV_PVT     = 8'h07;
    localparam logic [7:0] ID_NAV_SAT     = 8'h35;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NMEA = 2'd1,
        MODE_UBX  = 2'd2
    } line_mode_t;

    typedef enum logic [2:0] {
        EV_READ     = 3'd0,
        EV_GOOD     = 3'd1,
        EV_CSUM_BAD = 3'd2,
        EV_SYNC_BAD = 3'd3,
        EV_OVERLONG = 3'd4
    } event_kind_t;

    typedef enum logic [1:0] {
        SK_NONE = 2'd0,
        SK_RXM  = 2'd1,
        SK_PVT  = 2'd2,
        SK_SAT  = 2'd3
    } store_kind_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic [8:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        logic        ack_seen;
        logic [7:0]  acked_class;
        logic [7:0]  acked_id;
        logic [1:0]  store_kind;
        logic [7:0]  read_data;
    } out_item_t;

    // command from the parser front to the back
    typedef struct packed {
        logic              is_read;
        logic              rd_valid;   // read address in range
        logic [ADDR_W-1:0] rd_addr;
        logic              report;     // frame event
        logic [2:0]        kind;
        logic [7:0]        msg_class;
        logic [7:0]        msg_id;
        logic [15:0]       length;
        logic              ack_seen;
        logic [7:0]        acked_class;
        logic [7:0]        acked_id;
        logic [1:0]        store_kind;
    } cmd_t;

endpackage

// ----- src/ubx_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_if
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface ubx_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/ubx_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_front
// byte parser: writes the frame store, runs the checksum, issues commands
// ----------------------------------------------------------------------------
module ubx_front
    import ubx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  in_item_t in_data,
    output logic     in_ready,
    output logic     cmd_valid,
    output cmd_t     cmd_data,
    input  logic     cmd_ready,
    output logic     wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0] wr_data
);

    line_mode_t       mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sum_a_reg, sum_a_next, sum_b_reg, sum_b_next;
    logic [15:0]      len_reg, len_next;
    logic [7:0]       sync2_reg, sync2_next, cls_reg, cls_next, id_reg, id_next;
    logic [7:0]       len_lo_reg, len_lo_next, p0_reg, p0_next, p1_reg, p1_next;
    logic [7:0]       ck_a_reg, ck_a_next;

    logic       fire;
    logic [7:0] b;
    logic [16:0] total;

    assign in_ready = cmd_ready;
    assign fire     = in_valid && in_ready;
    assign b        = in_data.rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            len_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sync2_reg  <= sync2_next;
        cls_reg    <= cls_next;
        id_reg     <= id_next;
        len_lo_reg <= len_lo_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        ck_a_reg   <= ck_a_next;
    end

    always_comb
    begin
        logic [CNT_W-1:0] cnt1;
        logic [15:0]      flen;
        logic [7:0]       sa, sb;
        logic [16:0]      pos6;
        mode_next   = mode_reg;
        count_next  = count_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        len_next    = len_reg;
        sync2_next  = sync2_reg;
        cls_next    = cls_reg;
        id_next     = id_reg;
        len_lo_next = len_lo_reg;
        p0_next     = p0_reg;
        p1_next     = p1_reg;
        ck_a_next   = ck_a_reg;
        cmd_valid   = 1'b0;
        cmd_data    = '0;
        wr_en       = 1'b0;
        wr_addr     = count_reg[ADDR_W-1:0];
        wr_data     = b;
        cnt1        = count_reg + 1'b1;
        flen        = len_reg;
        total       = '0;
        sa          = sum_a_reg;
        sb          = sum_b_reg;
        pos6        = 17'(count_reg) - 17'd6;
        if (fire)
        begin
            if (in_data.action)
            begin
                cmd_valid        = 1'b1;
                cmd_data.is_read = 1'b1;
                cmd_data.rd_valid = (32'(in_data.read_index) + 6) < STORE_DEPTH;
                cmd_data.rd_addr = ADDR_W'(32'(in_data.read_index) + 6);
            end
            else if (mode_reg == MODE_IDLE || count_reg == '0)
            begin
                if (b == NMEA_START || b == UBX_SYNC1)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    count_next = CNT_W'(1);
                    mode_next  = (b == NMEA_START) ? MODE_NMEA : MODE_UBX;
                    if (b == UBX_SYNC1)
                    begin
                        sum_a_next = '0;
                        sum_b_next = '0;
                    end
                end
                else
                begin
                    count_next = '0;
                    mode_next  = MODE_IDLE;
                end
            end
            else if (mode_reg == MODE_NMEA)
            begin
                if (32'(count_reg) < STORE_DEPTH)
                begin
                    wr_en      = 1'b1;
                    count_next = cnt1;
                end
                if (b > NMEA_BAD_ABOVE || b == NMEA_LF)
                begin
                    count_next = '0;
                    mode_next  = MODE_IDLE;
                end
            end
            else if (32'(count_reg) >= STORE_DEPTH)
            begin
                count_next = '0;
                mode_next  = MODE_IDLE;
            end
            else
            begin
                wr_en      = 1'b1;
                count_next = cnt1;
                unique case (count_reg)
                    CNT_W'(1): sync2_next  = b;
                    CNT_W'(2): cls_next    = b;
                    CNT_W'(3): id_next     = b;
                    CNT_W'(4): len_lo_next = b;
                    CNT_W'(5): flen        = {b, len_lo_reg};
                    CNT_W'(6): p0_next     = b;
                    CNT_W'(7): p1_next     = b;
                    default: ;
                endcase
                if (count_reg == CNT_W'(6))
                    p0_next = b;
                if (count_reg == CNT_W'(5))
                    len_next = flen;
                // checksum and its first byte
                if (count_reg >= CNT_W'(2) &&
                    (count_reg < CNT_W'(6) || pos6 < 17'(len_reg)))
                begin
                    sa = sum_a_reg + b;
                    sb = sum_b_reg + sa;
                    sum_a_next = sa;
                    sum_b_next = sb;
                end
                if (count_reg >= CNT_W'(6) && pos6 == 17'(len_reg))
                    ck_a_next = b;
                total = 17'(flen) + 17'd8;
                if (count_reg == CNT_W'(5) && 32'(total) > STORE_DEPTH)
                begin
                    cmd_valid          = 1'b1;
                    cmd_data.report    = 1'b1;
                    cmd_data.kind      = EV_OVERLONG;
                    cmd_data.msg_class = cls_reg;
                    cmd_data.msg_id    = id_reg;
                    cmd_data.length    = flen;
                    count_next         = '0;
                    mode_next          = MODE_IDLE;
                end
                else if (count_reg >= CNT_W'(5) && 17'(cnt1) == total)
                begin
                    cmd_valid          = 1'b1;
                    cmd_data.report    = 1'b1;
                    cmd_data.msg_class = cls_reg;
                    cmd_data.msg_id    = id_reg;
                    cmd_data.length    = flen;
                    if (sync2_reg != UBX_SYNC2)
                        cmd_data.kind = EV_SYNC_BAD;
                    else if (ck_a_next != sum_a_reg || b != sum_b_reg)
                        cmd_data.kind = EV_CSUM_BAD;
                    else
                    begin
                        cmd_data.kind = EV_GOOD;
                        if (cls_reg == CLS_ACK && id_reg == ID_ACK_ACK)
                        begin
                            cmd_data.ack_seen    = 1'b1;
                            cmd_data.acked_class = p0_next;
                            cmd_data.acked_id    = (count_reg == CNT_W'(7)) ? b : p1_reg;
                        end
                        if (cls_reg == CLS_CFG && id_reg == ID_CFG_RXM)
                            cmd_data.store_kind = SK_RXM;
                        else if (cls_reg == CLS_NAV && id_reg == ID_NAV_PVT)
                            cmd_data.store_kind = SK_PVT;
                        else if (cls_reg == CLS_NAV && id_reg == ID_NAV_SAT)
                            cmd_data.store_kind = SK_SAT;
                    end
                    count_next = '0;
                    mode_next  = MODE_IDLE;
                end
            end
        end
    end

endmodule

// ----- src/ubx_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_back
// frame store memory, command register and two-entry result queue
// ----------------------------------------------------------------------------
module ubx_back
    import ubx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  cmd_t     cmd_data,
    output logic     cmd_ready,
    input  logic     wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0] wr_data,
    output logic     out_valid,
    output out_item_t out_data,
    input  logic     out_ready
);

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    // stage 1: command with memory read in flight
    logic s1_valid_reg;
    cmd_t s1_reg;

    // stage 2: output queue, two entries
    out_item_t q_reg [2];
    logic      q_wp_reg, q_rp_reg;
    logic [1:0] q_cnt_reg;

    out_item_t s1_out;
    logic      push, pop, s1_adv;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[cmd_data.rd_addr];
    end

    // a command may enter when the queue has room for everything in flight
    assign cmd_ready = (32'(q_cnt_reg) + (s1_valid_reg ? 1 : 0)) < 2 || pop;
    assign push   = s1_valid_reg;
    assign pop    = out_valid && out_ready;
    assign s1_adv = cmd_valid && cmd_ready;

    always_comb
    begin
        s1_out                = '0;
        s1_out.event_kind     = s1_reg.is_read ? EV_READ : s1_reg.kind;
        s1_out.msg_class      = s1_reg.msg_class;
        s1_out.msg_id         = s1_reg.msg_id;
        s1_out.payload_length = s1_reg.length;
        s1_out.ack_seen       = s1_reg.ack_seen;
        s1_out.acked_class    = s1_reg.acked_class;
        s1_out.acked_id       = s1_reg.acked_id;
        s1_out.store_kind     = s1_reg.store_kind;
        s1_out.read_data      = (s1_reg.is_read && s1_reg.rd_valid) ? rd_data_reg : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            q_wp_reg     <= 1'b0;
            q_rp_reg     <= 1'b0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_adv;
            if (push)
                q_wp_reg <= ~q_wp_reg;
            if (pop)
                q_rp_reg <= ~q_rp_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            s1_reg <= cmd_data;
        if (push)
            q_reg[q_wp_reg] <= s1_out;
    end

    assign out_valid = q_cnt_reg != '0;
    assign out_data  = q_reg[q_rp_reg];

endmodule

// ----- src/ubx_frame_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_frame_receiver
// ubx frame parser with fletcher checksum and payload read-back
// ----------------------------------------------------------------------------
// One item is taken each cycle while the back can accept a command. A read
// or frame event passes the stage-1 register and registered store read port,
// then the result queue. The front parses bytes and writes the store; a
// two-entry queue decouples it from output backpressure.
module ubx_frame_receiver
    import ubx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ubx_if.sink   in_ch,
    ubx_if.source out_ch
);

    logic     cmd_valid, cmd_ready, wr_en;
    cmd_t     cmd_data;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0] wr_data;
    in_item_t in_item;
    out_item_t out_item;

    assign in_item.action     = in_ch.data.action;
    assign in_item.rx_byte    = in_ch.data.rx_byte;
    assign in_item.read_index = in_ch.data.read_index;
    assign out_ch.data        = out_item;

    ubx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_data   (in_item),
        .in_ready  (in_ch.ready),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data),
        .cmd_ready (cmd_ready),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    ubx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data),
        .cmd_ready (cmd_ready),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (out_ch.valid),
        .out_data  (out_item),
        .out_ready (out_ch.ready)
    );

    a_read_has_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_item.event_kind == EV_READ |-> out_item.ack_seen == 1'b0)
        else $error("read result carries frame fields");

    a_ack_only_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_item.ack_seen |-> out_item.event_kind == EV_GOOD)
        else $error("ack flag on bad frame");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_item.action |-> !wr_en)
        else $error("store written on read");

endmodule
